/* src/cfim_pkg.sv */
// shared types, constants and register codes for the CAN frame interval monitor
package cfim_pkg;

	// field widths
	localparam int ID_W     = 29;
	localparam int TS_W     = 40;
	localparam int LIMIT_W  = 24;
	localparam int COUNT_W  = 32;
	localparam int TOTAL_W  = 48;
	localparam int SLOT_W   = 3;
	localparam int SLOTS    = 8;
	localparam int TIME_BITS_DEF = 40;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ACTIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT     = 2'd2;

	localparam logic [LIMIT_W-1:0] FAST_LIMIT_RST = 24'd150;
	localparam logic [LIMIT_W-1:0] SLOW_LIMIT_RST = 24'd15000;

	// item kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// monitored identifiers
	localparam logic [ID_W-1:0] ID_SINGLE     = 29'h207;
	localparam logic [ID_W-1:0] ID_GROUP_LO   = 29'h2C0;
	localparam logic [ID_W-1:0] ID_GROUP_HI   = 29'h2C6;
	localparam logic [ID_W-1:0] ID_SLOW_LO    = 29'h2C3;
	localparam logic [ID_W-1:0] ID_SLOW_HI    = 29'h2C5;

	// per-slot statistics
	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic [TOTAL_W-1:0] interval_total;
		logic [TS_W-1:0]    interval_max;
		logic [COUNT_W-1:0] late_count;
	} stats_t;

	// what one frame measured
	typedef struct packed {
		logic            interval_valid;
		logic [TS_W-1:0] interval;
		logic            late;
	} meas_t;

	// one result item
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		meas_t             meas;
		stats_t            stats;
	} result_t;

endpackage

/* src/cfim_if.sv */
// valid/ready channel interfaces for frame events and slot statistics

interface cfim_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [cfim_pkg::ID_W-1:0]     frame_id;
	logic [cfim_pkg::TS_W-1:0]     timestamp_ms;

	modport source (output valid, kind, frame_id, timestamp_ms, input ready);
	modport sink   (input valid, kind, frame_id, timestamp_ms, output ready);
endinterface

interface cfim_out_if;
	logic                          valid;
	logic                          ready;
	logic [cfim_pkg::SLOT_W-1:0]   slot;
	logic                          interval_valid;
	logic [cfim_pkg::TS_W-1:0]     interval_ms;
	logic                          late;
	logic [cfim_pkg::COUNT_W-1:0]  frame_count;
	logic [cfim_pkg::TOTAL_W-1:0]  interval_total_ms;
	logic [cfim_pkg::TS_W-1:0]     interval_max_ms;
	logic [cfim_pkg::COUNT_W-1:0]  late_count;

	modport source (output valid, slot, interval_valid, interval_ms, late, frame_count,
		interval_total_ms, interval_max_ms, late_count, input ready);
	modport sink   (input valid, slot, interval_valid, interval_ms, late, frame_count,
		interval_total_ms, interval_max_ms, late_count, output ready);
endinterface

/* src/can_frame_interval_monitor.sv */
// top level of the CAN frame interval monitor: input stage, slot table, result register
//
// Usage:
//   frames  : sink channel of frame events (kind, frame_id, timestamp_ms).
//             kind clear empties every slot and gives no result; a frame
//             with measurement off or with an unmonitored identifier is
//             dropped without a result.
//   stats   : source channel; one transfer per monitored frame with the
//             slot's updated statistics.
//   cfg_*   : register writes (measure_active, fast_limit_ms,
//             slow_limit_ms), to be done while the block is idle.
// Path: a frame is registered in the input stage and its result in the
//   result register, which offers it on stats.
// Throughput: one frame per cycle unless a stalled result holds the input
//   stage; the slot table is flip-flops read and written back in the same
//   cycle, so back-to-back frames of one slot see each other's updates.
// Reset: measurement off, limits 150 and 15000 ms, all slots empty.
// Stall: a result waits in the output register; the input stage holds one
//   more frame, then frames.ready drops until stats.ready returns.
module can_frame_interval_monitor #(
	parameter int TIME_BITS = cfim_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	cfim_in_if.sink                            frames,
	cfim_out_if.source                         stats,
	input  logic                               cfg_we,
	input  logic [cfim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfim_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	localparam int TS_W   = cfim_pkg::TS_W;
	localparam int SLOTS  = cfim_pkg::SLOTS;
	localparam int SLOT_W = cfim_pkg::SLOT_W;
	localparam int ID_W   = cfim_pkg::ID_W;
	localparam int LW     = cfim_pkg::LIMIT_W;
	localparam int TW     = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;

	// configuration registers
	logic          measure_q;
	logic [LW-1:0] fast_limit_q;
	logic [LW-1:0] slow_limit_q;

	// input stage
	logic            valid_s1;
	logic            kind_s1;
	logic [ID_W-1:0] id_s1;
	logic [TW-1:0]   time_s1;

	// slot table
	logic [SLOTS-1:0]          seen_q;
	logic [TW-1:0]             last_time_q [SLOTS];
	cfim_pkg::stats_t          stats_q     [SLOTS];

	// result register
	logic                      out_valid_q;
	cfim_pkg::result_t         res_q;

	logic                      is_single;
	logic                      in_group;
	logic                      is_slow;
	logic                      hit;
	logic [SLOT_W-1:0]         slot;
	logic [LW-1:0]             limit;
	logic                      out_free;
	logic                      fire_s1;
	logic                      load_out;
	cfim_pkg::stats_t          nxt_stats;
	cfim_pkg::meas_t           meas;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_q    <= 1'b0;
			fast_limit_q <= cfim_pkg::FAST_LIMIT_RST;
			slow_limit_q <= cfim_pkg::SLOW_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cfim_pkg::REG_MEASURE_ACTIVE: measure_q    <= cfg_wdata[0];
				cfim_pkg::REG_FAST_LIMIT:     fast_limit_q <= cfg_wdata;
				cfim_pkg::REG_SLOW_LIMIT:     slow_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// identifier decode
	assign is_single = (id_s1 == cfim_pkg::ID_SINGLE);
	assign in_group  = (id_s1 >= cfim_pkg::ID_GROUP_LO) && (id_s1 <= cfim_pkg::ID_GROUP_HI);
	assign is_slow   = (id_s1 >= cfim_pkg::ID_SLOW_LO) && (id_s1 <= cfim_pkg::ID_SLOW_HI);
	assign slot      = is_single ? '0 : SLOT_W'(id_s1 - cfim_pkg::ID_GROUP_LO + 1'b1);
	assign limit     = is_slow ? slow_limit_q : fast_limit_q;
	assign hit       = valid_s1 && (kind_s1 == cfim_pkg::KIND_FRAME) && measure_q
		&& (is_single || in_group);

	// handshake: a frame that yields a result needs room in the result register
	assign out_free     = !out_valid_q || stats.ready;
	assign fire_s1      = valid_s1 && (!hit || out_free);
	assign load_out     = fire_s1 && hit;
	assign frames.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			kind_s1 <= frames.kind;
			id_s1   <= frames.frame_id;
			time_s1 <= frames.timestamp_ms[TW-1:0];
		end
	end

	cfim_stats_update #(
		.TW (TW)
	) u_update (
		.seen      (seen_q[slot]),
		.last_time (last_time_q[slot]),
		.now       (time_s1),
		.limit     (limit),
		.cur       (stats_q[slot]),
		.nxt       (nxt_stats),
		.meas      (meas)
	);

	// slot statistics: clear empties all, a monitored frame writes its slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				stats_q[i] <= '0;
			end
		end else if (fire_s1 && (kind_s1 == cfim_pkg::KIND_CLEAR)) begin
			seen_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				stats_q[i] <= '0;
			end
		end else if (load_out) begin
			seen_q[slot]  <= 1'b1;
			stats_q[slot] <= nxt_stats;
		end
	end

	// last timestamps, only read once their slot has been seen
	always_ff @(posedge clk) begin
		if (load_out) begin
			last_time_q[slot] <= time_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.slot  <= slot;
			res_q.meas  <= meas;
			res_q.stats <= nxt_stats;
		end
	end

	assign stats.valid             = out_valid_q;
	assign stats.slot              = res_q.slot;
	assign stats.interval_valid    = res_q.meas.interval_valid;
	assign stats.interval_ms       = res_q.meas.interval;
	assign stats.late              = res_q.meas.late;
	assign stats.frame_count       = res_q.stats.frame_count;
	assign stats.interval_total_ms = res_q.stats.interval_total;
	assign stats.interval_max_ms   = res_q.stats.interval_max;
	assign stats.late_count        = res_q.stats.late_count;

	// a clear transfer leaves no slot marked as seen
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (kind_s1 == cfim_pkg::KIND_CLEAR) |=> seen_q == '0)
		else $error("slot still marked seen after clear");

	// every loaded result counts at least the frame itself
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> stats.valid && stats.frame_count != '0)
		else $error("result loaded with zero frame count");

	// late only when an interval was measured
	a_late_measured: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid && stats.late |-> stats.interval_valid)
		else $error("late flagged without interval");

	// no interval means zero interval
	a_no_interval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid && !stats.interval_valid |-> stats.interval_ms == '0)
		else $error("interval value without measurement");

	// input backpressure only while the input stage holds a frame
	a_ready_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!frames.ready |-> valid_s1 && hit && out_valid_q)
		else $error("input stalled without a blocked result");

endmodule

/* src/cfim_stats_update.sv */
// next-state logic for one slot: interval, late check, saturating counters
module cfim_stats_update #(
	parameter int TW = cfim_pkg::TIME_BITS_DEF
) (
	input  logic                            seen,
	input  logic [TW-1:0]                   last_time,
	input  logic [TW-1:0]                   now,
	input  logic [cfim_pkg::LIMIT_W-1:0]    limit,
	input  cfim_pkg::stats_t                cur,
	output cfim_pkg::stats_t                nxt,
	output cfim_pkg::meas_t                 meas
);
	localparam int TS_W    = cfim_pkg::TS_W;
	localparam int TOTAL_W = cfim_pkg::TOTAL_W;
	localparam int COUNT_W = cfim_pkg::COUNT_W;

	logic                 measured;
	logic [TW-1:0]        diff;
	logic [TS_W-1:0]      interval;
	logic                 over;
	logic [TOTAL_W:0]     sum;

	// interval only when an earlier time exists and time did not run backwards
	assign measured = seen && (now >= last_time);
	assign diff     = now - last_time;
	assign interval = measured ? TS_W'(diff) : '0;
	assign over     = measured && (interval > TS_W'(limit));
	assign sum      = {1'b0, cur.interval_total} + (TOTAL_W + 1)'(interval);

	assign meas.interval_valid = measured;
	assign meas.interval       = interval;
	assign meas.late           = over;

	// saturating counters, running total and maximum
	always_comb begin
		nxt = cur;
		if (cur.frame_count != {COUNT_W{1'b1}}) begin
			nxt.frame_count = cur.frame_count + 1'b1;
		end
		if (measured) begin
			nxt.interval_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
			if (interval > cur.interval_max) begin
				nxt.interval_max = interval;
			end
		end
		if (over && (cur.late_count != {COUNT_W{1'b1}})) begin
			nxt.late_count = cur.late_count + 1'b1;
		end
	end

endmodule
